// File: rtl/wfs_pkg.sv
// Shared types, constants and helper functions for the whole-word substring finder.
// No dependencies; imported by every module of the block.
package wfs_pkg;

   localparam int MAX_PATTERN   = 8;
   localparam int CHAR_BITS     = 16;
   localparam int POS_BITS      = 32;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CHARS_PER_REG = CSR_DATA_BITS / CHAR_BITS;
   localparam int LEN_BITS      = 4;
   localparam int IDX_BITS      = $clog2(MAX_PATTERN);
   localparam int CNT_MAX       = MAX_PATTERN + 1;
   localparam int CNT_BITS      = $clog2(CNT_MAX + 1);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_UPPER_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UPPER_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWER_LOW  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWER_HIGH = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAT_LEN    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WHOLE_WORD = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BACKWARD   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START      = 3'd7;

   // one character after the window shift, waiting for the decision stage
   typedef struct packed {
      logic                first;
      logic                last;
      logic                eot;
      logic [CNT_BITS-1:0] cnt;
      logic [POS_BITS-1:0] start;
      logic                letter_before;
   } stage_type;

   typedef struct packed {
      logic                done;
      logic                found;
      logic [POS_BITS-1:0] pos;
   } result_type;

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] v;
      v = c;
      is_letter = (v >= CHAR_BITS'(16'h41)  && v <= CHAR_BITS'(16'h5A))  ||
                  (v >= CHAR_BITS'(16'h61)  && v <= CHAR_BITS'(16'h7A))  ||
                  (v >= CHAR_BITS'(16'hC0)  && v <= CHAR_BITS'(16'h24F) &&
                   v != CHAR_BITS'(16'hD7)  && v != CHAR_BITS'(16'hF7))  ||
                  (v >= CHAR_BITS'(16'h370) && v <= CHAR_BITS'(16'h52F));
   endfunction

   // pattern length limited to the window depth
   function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] l);
      clamp_len = (l > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : l;
   endfunction

endpackage

// File: rtl/wfs_cell.sv
// One window cell: holds a text character and its letter flag, compares it with its pattern char.
// Depends on wfs_pkg.
module wfs_cell (
   input  logic                          clock,
   input  logic                          shift,
   input  logic                          restart,
   input  logic [wfs_pkg::CHAR_BITS-1:0] prev_char,
   input  logic [wfs_pkg::CHAR_BITS-1:0] pat_upper,
   input  logic [wfs_pkg::CHAR_BITS-1:0] pat_lower,
   output logic [wfs_pkg::CHAR_BITS-1:0] char_q,
   output logic                          match_q,
   output logic                          letter_q
);
   import wfs_pkg::*;

   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic                 letter_ff, letter_in;

   always_comb begin
      char_in   = restart ? '0 : prev_char;
      letter_in = is_letter(char_in);
   end

   // payload only; validity is tracked by the stage behind the row
   always_ff @(posedge clock) begin
      if (shift) begin
         char_ff   <= char_in;
         letter_ff <= letter_in;
      end
   end

   // compared against the current pattern, so new settings apply to the held window
   assign char_q   = char_ff;
   assign match_q  = (char_ff == pat_upper) || (char_ff == pat_lower);
   assign letter_q = letter_ff;

endmodule

// File: rtl/wfs_decide.sv
// Decision stage: pattern hit, whole-word rule, pending candidate and latched match.
// Depends on wfs_pkg; fed by the row of wfs_cell.
module wfs_decide (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  wfs_pkg::stage_type            stage,
   input  logic [wfs_pkg::MAX_PATTERN-1:0] match,
   input  logic [wfs_pkg::MAX_PATTERN-1:0] letter,
   input  logic [wfs_pkg::LEN_BITS-1:0]  len,
   input  logic                          whole_word,
   input  logic                          backward,
   input  logic [wfs_pkg::POS_BITS-1:0]  search_start,
   output wfs_pkg::result_type           result
);
   import wfs_pkg::*;

   logic                pend_ff, pend_in;
   logic [POS_BITS-1:0] pend_pos_ff, pend_pos_in;
   logic                lat_ff, lat_in;
   logic [POS_BITS-1:0] lat_pos_ff, lat_pos_in;

   logic [MAX_PATTERN-1:0] in_use;
   logic                   hit, before_ok, pend_ge, start_ge, pend_take;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         in_use[k] = LEN_BITS'(k) < len;
      end
      hit = (len != '0) && (stage.cnt >= CNT_BITS'(len)) && (&(match | ~in_use));
      if (stage.cnt <= CNT_BITS'(len)) begin
         before_ok = 1'b1;
      end else if (len < LEN_BITS'(MAX_PATTERN)) begin
         before_ok = !letter[len[IDX_BITS-1:0]];
      end else begin
         before_ok = !stage.letter_before;
      end
      pend_ge   = pend_pos_ff >= search_start;
      start_ge  = stage.start >= search_start;
      pend_take = pend_ff && (stage.first || !letter[0]);
   end

   always_comb begin
      lat_in      = lat_ff;
      lat_pos_in  = lat_pos_ff;
      pend_in     = 1'b0;
      pend_pos_in = pend_pos_ff;
      // candidate from the previous character is settled first
      if (pend_take) begin
         if (backward) begin
            if (!pend_ge) begin
               lat_in     = 1'b1;
               lat_pos_in = pend_pos_ff;
            end
         end else if (!lat_in && pend_ge) begin
            lat_in     = 1'b1;
            lat_pos_in = pend_pos_ff;
         end
      end
      if (hit && (!whole_word || before_ok)) begin
         if (whole_word && !(stage.last || stage.eot)) begin
            pend_in     = 1'b1;
            pend_pos_in = stage.start;
         end else if (backward) begin
            if (!start_ge) begin
               lat_in     = 1'b1;
               lat_pos_in = stage.start;
            end
         end else if (!lat_in && start_ge) begin
            lat_in     = 1'b1;
            lat_pos_in = stage.start;
         end
      end
      result.done  = fire && stage.eot;
      result.found = lat_in;
      result.pos   = lat_in ? lat_pos_in : '0;
      if (stage.eot) begin
         lat_in  = 1'b0;
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         lat_ff  <= 1'b0;
      end else if (fire) begin
         pend_ff <= pend_in;
         lat_ff  <= lat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_pos_ff <= pend_pos_in;
         lat_pos_ff  <= lat_pos_in;
      end
   end

endmodule

// File: rtl/whole_word_substring_finder.sv
// Top level of the streaming whole-word substring finder: registers, cell row, output stage.
// Depends on wfs_pkg, wfs_cell and wfs_decide.
//
// Usage:
//  - req_ carries one text character per transfer; req_tlast marks the final character
//    of a text, which triggers exactly one rsp_ transfer (found flag and match start).
//  - csr_ writes the pattern and search settings; write only while the block is idle.
//  - One character per cycle is taken back to back unless a stall holds req_tready low. Each
//    transfer shifts the row of window cells; the decision stage behind it works on the
//    registered character. The result of an end-of-text character is registered in the
//    output register, which drives rsp_tvalid.
//  - Stall: a result waits in the output register while new characters keep flowing;
//    only a second end-of-text reaching the decision stage while the earlier result is
//    still untaken holds req_tready low, for as long as rsp_tready stays low.
//  - Reset (synchronous, active high) clears the settings to zero and the search state;
//    the next text starts from an empty window.
module whole_word_substring_finder (
   input  logic        clock,
   input  logic        reset,
   // text characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] ch, [47:16] position
   input  logic [1:0]  req_tuser,   // [0] first_in_para, [1] last_in_para
   input  logic        req_tlast,   // end_of_text
   // search result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] match_position
   output logic [0:0]  rsp_tuser,   // [0] found
   // settings
   input  logic        csr_we,
   input  logic [wfs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [wfs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import wfs_pkg::*;

   // settings
   logic [CSR_DATA_BITS-1:0] upper_low_ff, upper_high_ff, lower_low_ff, lower_high_ff;
   logic [LEN_BITS-1:0]      pat_len_ff;
   logic                     whole_word_ff, backward_ff;
   logic [POS_BITS-1:0]      start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_low_ff  <= '0;
         upper_high_ff <= '0;
         lower_low_ff  <= '0;
         lower_high_ff <= '0;
         pat_len_ff    <= '0;
         whole_word_ff <= 1'b0;
         backward_ff   <= 1'b0;
         start_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPPER_LOW:  upper_low_ff  <= csr_wdata;
            CSR_UPPER_HIGH: upper_high_ff <= csr_wdata;
            CSR_LOWER_LOW:  lower_low_ff  <= csr_wdata;
            CSR_LOWER_HIGH: lower_high_ff <= csr_wdata;
            CSR_PAT_LEN:    pat_len_ff    <= csr_wdata[LEN_BITS-1:0];
            CSR_WHOLE_WORD: whole_word_ff <= csr_wdata[0];
            CSR_BACKWARD:   backward_ff   <= csr_wdata[0];
            CSR_START:      start_ff      <= csr_wdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [LEN_BITS-1:0]  len_c, len_m1;
   logic [CHAR_BITS-1:0] upper_chars [MAX_PATTERN];
   logic [CHAR_BITS-1:0] lower_chars [MAX_PATTERN];

   assign len_c  = clamp_len(pat_len_ff);
   assign len_m1 = len_c - LEN_BITS'(1);   // wraps for an empty pattern, never used then

   always_comb begin
      for (int i = 0; i < CHARS_PER_REG; i++) begin
         upper_chars[i]               = upper_low_ff[i*CHAR_BITS +: CHAR_BITS];
         lower_chars[i]               = lower_low_ff[i*CHAR_BITS +: CHAR_BITS];
         upper_chars[i+CHARS_PER_REG] = upper_high_ff[i*CHAR_BITS +: CHAR_BITS];
         lower_chars[i+CHARS_PER_REG] = lower_high_ff[i*CHAR_BITS +: CHAR_BITS];
      end
   end

   // handshake and stage control
   logic       accept;
   logic       b_valid_ff, b_valid_in, b_fire, b_blocked;
   stage_type  b_ff, b_in;
   logic       restart_ff;   // next character opens a fresh text
   logic [CNT_BITS-1:0] para_cnt_ff, para_cnt_in, cnt_base, cnt_new;
   logic       rsp_valid_ff;
   logic       rsp_found_ff;
   logic [POS_BITS-1:0] rsp_pos_ff;
   result_type result;

   logic [CHAR_BITS-1:0]   req_ch;
   logic [POS_BITS-1:0]    req_pos;
   logic                   req_first, req_last;

   assign req_ch    = req_tdata[CHAR_BITS-1:0];
   assign req_pos   = req_tdata[CHAR_BITS +: POS_BITS];
   assign req_first = req_tuser[0];
   assign req_last  = req_tuser[1];

   // an end-of-text character cannot be decided while the last result is still held,
   // unless that result leaves on this very edge
   assign b_blocked  = b_valid_ff && b_ff.eot && rsp_valid_ff && !rsp_tready;
   assign req_tready = !b_blocked;
   assign accept     = req_tvalid && req_tready;
   assign b_fire     = b_valid_ff && !b_blocked;
   assign b_valid_in = accept || (b_valid_ff && b_blocked);

   // row of window cells, cell 0 takes the newest character
   logic [CHAR_BITS-1:0]   cell_char [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_match, cell_letter;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [LEN_BITS-1:0]  pat_idx;
      logic [CHAR_BITS-1:0] prev;
      assign pat_idx = len_m1 - LEN_BITS'(k);
      if (k == 0) begin : g_head
         assign prev = req_ch;
      end else begin : g_body
         assign prev = cell_char[k-1];
      end
      wfs_cell u_cell (
         .clock     (clock),
         .shift     (accept),
         .restart   ((k != 0) && restart_ff),
         .prev_char (prev),
         .pat_upper (upper_chars[pat_idx[IDX_BITS-1:0]]),
         .pat_lower (lower_chars[pat_idx[IDX_BITS-1:0]]),
         .char_q    (cell_char[k]),
         .match_q   (cell_match[k]),
         .letter_q  (cell_letter[k])
      );
   end

   // paragraph character count, saturating above the window depth
   always_comb begin
      cnt_base = (restart_ff || req_first) ? '0 : para_cnt_ff;
      cnt_new  = (cnt_base == CNT_BITS'(CNT_MAX)) ? cnt_base : cnt_base + CNT_BITS'(1);
      para_cnt_in = para_cnt_ff;
      if (accept) begin
         para_cnt_in = req_last ? '0 : cnt_new;
      end
      b_in.first         = req_first;
      b_in.last          = req_last;
      b_in.eot           = req_tlast;
      b_in.cnt           = cnt_new;
      b_in.start         = req_pos - POS_BITS'(len_m1);
      b_in.letter_before = !restart_ff && cell_letter[MAX_PATTERN-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff  <= 1'b1;
         para_cnt_ff <= '0;
         b_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            restart_ff <= req_tlast;
         end
         para_cnt_ff <= para_cnt_in;
         b_valid_ff  <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ff <= b_in;
      end
   end

   wfs_decide u_decide (
      .clock        (clock),
      .reset        (reset),
      .fire         (b_fire),
      .stage        (b_ff),
      .match        (cell_match),
      .letter       (cell_letter),
      .len          (len_c),
      .whole_word   (whole_word_ff),
      .backward     (backward_ff),
      .search_start (start_ff),
      .result       (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_found_ff <= result.found;
         rsp_pos_ff   <= result.pos;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pos_ff;
   assign rsp_tuser[0] = rsp_found_ff;

`ifndef NO_ASSERTIONS
   a_block_eot: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_ff.eot && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while a finished result still blocks the decision stage");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an untaken result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      result.done |=> rsp_tvalid)
      else $error("decided result did not reach the output register");

   a_eot_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (b_valid_ff && b_ff.eot))
      else $error("end-of-text transfer lost before the decision stage");

   a_zero_when_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("match position not zero on a not-found result");
`endif

endmodule

// File: tb/sv/whole_word_substring_finder_tb.sv
// Self-checking testbench for whole_word_substring_finder: a directed table, then random texts.
// Depends on wfs_pkg and the block's RTL; end-of-text results are predicted inside this file.
module whole_word_substring_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wfs_pkg::*;

   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int DRAIN_CYCLES = 8;      // flush of the output path, with margin
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 50;     // 600 characters over all phases, plus overshoot
   localparam int PRESSURE_PH  = 5;

   // one text character as it travels on req_
   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic [POS_BITS-1:0]  pos;
      logic                 first;
      logic                 last;
      logic                 eot;
   } text_char_type;

   // what one rsp_ transfer should carry
   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] pos;
   } outcome_type;

   typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] wdata;
      text_char_type            c;
      logic                     typed;   // expected result written into the row
      outcome_type              want;
   } row_type;

   // ---------------------------------------------------------------- signals
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [47:0]              req_tdata  = '0;
   logic [1:0]               req_tuser  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [31:0]              rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   whole_word_substring_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] ch, [47:16] position
      .req_tuser  (req_tuser),    // [0] first_in_para, [1] last_in_para
      .req_tlast  (req_tlast),    // end_of_text
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] match_position
      .rsp_tuser  (rsp_tuser),    // [0] found
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------- predictor state
   // settings as last written
   logic [63:0]         up_lo = '0, up_hi = '0, lo_lo = '0, lo_hi = '0;
   logic [3:0]          pat_len   = '0;
   logic                whole     = 1'b0;
   logic                backward  = 1'b0;
   logic [POS_BITS-1:0] start_pos = '0;

   // scan state, newest character in win[0]
   logic [CHAR_BITS-1:0] win [MAX_PATTERN];
   int                   para_cnt;
   logic                 letter_before;
   logic                 pend;
   logic [POS_BITS-1:0]  pend_pos;
   logic                 latched;
   logic [POS_BITS-1:0]  latched_pos;

   outcome_type search_outcomes [$];   // results still owed by the block, oldest first
   row_type     directed_rows [$];
   int          errors     = 0;
   int          sent_items = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;

   function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
      return (c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A) ||
             (c >= 16'hC0 && c <= 16'h24F && c != 16'hD7 && c != 16'hF7) ||
             (c >= 16'h370 && c <= 16'h52F);
   endfunction

   // pattern character i, upper or lower form
   function automatic logic [CHAR_BITS-1:0] slot_char(input logic lower_form, input int i);
      logic [63:0] w;
      if (lower_form) begin
         w = (i < 4) ? lo_lo : lo_hi;
      end else begin
         w = (i < 4) ? up_lo : up_hi;
      end
      return w[16*(i%4) +: 16];
   endfunction

   function automatic void clear_scan();
      for (int i = 0; i < MAX_PATTERN; i++) win[i] = '0;
      para_cnt      = 0;
      letter_before = 1'b0;
      pend          = 1'b0;
      pend_pos      = '0;
      latched       = 1'b0;
      latched_pos   = '0;
   endfunction

   // forward keeps the first start at or after start_pos, backward the last one before it
   function automatic void offer_match(input logic [POS_BITS-1:0] st);
      if (backward) begin
         if (st < start_pos) begin
            latched     = 1'b1;
            latched_pos = st;
         end
      end else if (!latched && st >= start_pos) begin
         latched     = 1'b1;
         latched_pos = st;
      end
   endfunction

   // steps the scan by one character; returns 1 with the result on end of text
   function automatic logic advance_search(input text_char_type c, output outcome_type res);
      int                   len;
      logic                 hit;
      logic                 before_ok;
      logic [POS_BITS-1:0]  st;
      logic [CHAR_BITS-1:0] t;
      len = (int'(pat_len) > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      res = '0;
      // a whole-word candidate waits for the character after it
      if (pend) begin
         if (c.first || !is_alpha(c.ch)) offer_match(pend_pos);
         pend = 1'b0;
      end
      if (c.first) para_cnt = 0;
      letter_before = is_alpha(win[MAX_PATTERN-1]);
      for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = c.ch;
      if (para_cnt < MAX_PATTERN + 1) para_cnt++;
      hit = (len > 0) && (para_cnt >= len);
      for (int i = 0; i < len; i++) begin
         t = win[len-1-i];
         if (t != slot_char(1'b0, i) && t != slot_char(1'b1, i)) hit = 1'b0;
      end
      if (hit) begin
         st = c.pos - POS_BITS'(len - 1);
         if (whole) begin
            if (para_cnt <= len) begin
               before_ok = 1'b1;
            end else if (len < MAX_PATTERN) begin
               before_ok = !is_alpha(win[len]);
            end else begin
               before_ok = !letter_before;
            end
            if (before_ok) begin
               if (c.last || c.eot) begin
                  offer_match(st);
               end else begin
                  pend     = 1'b1;
                  pend_pos = st;
               end
            end
         end else begin
            offer_match(st);
         end
      end
      if (c.last) para_cnt = 0;
      if (c.eot) begin
         res.found = latched;
         res.pos   = latched ? latched_pos : '0;
         clear_scan();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------- drivers
   // inputs move on the falling edge, transfers are seen on the rising edge
   task automatic send_char(input text_char_type c, input logic typed,
                            input outcome_type want);
      outcome_type res;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {c.pos, c.ch};
      req_tuser  = {c.last, c.first};
      req_tlast  = c.eot;
      do @(posedge clock); while (!req_tready);
      if (advance_search(c, res)) search_outcomes.push_back(typed ? want : res);
   endtask

   // lets the block go idle: no transfer offered, nothing owed, pipeline flushed
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (search_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_UPPER_LOW:  up_lo     = v;
         CSR_UPPER_HIGH: up_hi     = v;
         CSR_LOWER_LOW:  lo_lo     = v;
         CSR_LOWER_HIGH: lo_hi     = v;
         CSR_PAT_LEN:    pat_len   = v[3:0];
         CSR_WHOLE_WORD: whole     = v[0];
         CSR_BACKWARD:   backward  = v[0];
         CSR_START:      start_pos = v[31:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------- directed table
   task automatic add_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] v);
      row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.wdata = v;
      directed_rows.push_back(r);
   endtask

   task automatic add_char(input logic [15:0] ch, input logic [31:0] pos,
                           input logic fp, input logic lp, input logic eot);
      row_type r;
      r      = '0;
      r.kind = ROW_CHAR;
      r.c    = '{ch: ch, pos: pos, first: fp, last: lp, eot: eot};
      directed_rows.push_back(r);
   endtask

   task automatic add_typed(input logic [15:0] ch, input logic [31:0] pos,
                            input logic found, input logic [31:0] mpos);
      row_type r;
      r       = '0;
      r.kind  = ROW_CHAR;
      r.c     = '{ch: ch, pos: pos, first: 1'b1, last: 1'b1, eot: 1'b1};
      r.typed = 1'b1;
      r.want  = '{found: found, pos: mpos};
      directed_rows.push_back(r);
   endtask

   // ------------------------------------------------------- random content
   function automatic logic [CHAR_BITS-1:0] noise_char();
      logic [CHAR_BITS-1:0] v;
      case ($urandom_range(6))
         0: v = CHAR_BITS'($urandom);
         1: begin
            // either side of each letter range
            case ($urandom_range(19))
               0:  v = 16'h0000;  1:  v = 16'h0040;  2:  v = 16'h0041;  3:  v = 16'h005A;
               4:  v = 16'h005B;  5:  v = 16'h0060;  6:  v = 16'h0061;  7:  v = 16'h007A;
               8:  v = 16'h007B;  9:  v = 16'h00BF;  10: v = 16'h00C0;  11: v = 16'h00D7;
               12: v = 16'h00F7;  13: v = 16'h024F;  14: v = 16'h0250;  15: v = 16'h036F;
               16: v = 16'h0370;  17: v = 16'h052F;  18: v = 16'h0530;  default: v = 16'hFFFF;
            endcase
         end
         2: v = $urandom_range(1) ? CHAR_BITS'($urandom_range(16'h41, 16'h5A))
                                  : CHAR_BITS'($urandom_range(16'h61, 16'h7A));
         3: v = CHAR_BITS'($urandom_range(16'hC0, 16'h52F));
         6: v = CHAR_BITS'($urandom_range(16'h20, 16'h40));
         default: v = slot_char(1'($urandom_range(1)), $urandom_range(MAX_PATTERN - 1));
      endcase
      return v;
   endfunction

   // new pattern and search settings; every register written, upper bits of the narrow
   // ones filled with junk
   task automatic configure_phase(input int ph, output logic [POS_BITS-1:0] base);
      logic [63:0]          ul, uh, ll, lh;
      logic [CHAR_BITS-1:0] u, l;
      logic [3:0]           len;
      logic [POS_BITS-1:0]  st;
      int                   k;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         k = $urandom_range(25);
         case ($urandom_range(3))
            0: begin u = CHAR_BITS'(16'h41 + k); l = CHAR_BITS'(16'h61 + k); end
            1: begin u = noise_char(); l = u; end
            2: begin u = CHAR_BITS'($urandom); l = CHAR_BITS'($urandom); end
            default: begin u = CHAR_BITS'(16'h41 + k); l = u; end   // case matters
         endcase
         if (i < 4) begin
            ul[16*i +: 16] = u;
            ll[16*i +: 16] = l;
         end else begin
            uh[16*(i-4) +: 16] = u;
            lh[16*(i-4) +: 16] = l;
         end
      end
      if (ph == 0) begin
         len = 4'd8;
      end else begin
         case ($urandom_range(9))
            0:       len = 4'd0;
            1:       len = 4'($urandom_range(9, 15));   // clamped to the window
            default: len = 4'($urandom_range(1, 8));
         endcase
      end
      case ($urandom_range(3))
         0:       base = '0;
         1:       base = 32'hFFFF_FFE0;                 // positions wrap inside the text
         default: base = POS_BITS'($urandom);
      endcase
      case ($urandom_range(5))
         0:       st = '0;
         1:       st = '1;
         default: st = base + POS_BITS'($urandom_range(60));
      endcase
      drain_results();
      write_reg(CSR_UPPER_LOW, ul);
      write_reg(CSR_UPPER_HIGH, uh);
      write_reg(CSR_LOWER_LOW, ll);
      write_reg(CSR_LOWER_HIGH, lh);
      write_reg(CSR_PAT_LEN, {32'($urandom), 28'($urandom), len});
      write_reg(CSR_WHOLE_WORD, {32'($urandom), 31'($urandom), 1'($urandom_range(1))});
      write_reg(CSR_BACKWARD, {32'($urandom), 31'($urandom), 1'($urandom_range(1))});
      write_reg(CSR_START, {32'($urandom), st});
   endtask

   // one text of one to three paragraphs; most plant the pattern, a few carry random marks
   task automatic run_text(input logic [POS_BITS-1:0] base);
      logic [CHAR_BITS-1:0] body [$];
      logic [POS_BITS-1:0]  pos;
      text_char_type        c;
      logic                 noisy;
      int                   paras, plen, len, at;
      noisy = ($urandom_range(9) == 0);
      pos   = base + POS_BITS'($urandom_range(30));
      paras = $urandom_range(1, 3);
      len   = (int'(pat_len) > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      for (int p = 0; p < paras; p++) begin
         plen = $urandom_range(1, 10);
         body.delete();
         for (int k = 0; k < plen; k++) body.push_back(noise_char());
         if (!noisy && len > 0 && len <= plen && $urandom_range(99) < 65) begin
            at = $urandom_range(plen - len);
            for (int i = 0; i < len; i++) body[at+i] = slot_char(1'($urandom_range(1)), i);
         end
         for (int k = 0; k < plen; k++) begin
            c.ch  = body[k];
            c.pos = pos;
            if (noisy) begin
               c.first = ($urandom_range(3) == 0);
               c.last  = ($urandom_range(3) == 0);
            end else begin
               c.first = (k == 0) && ($urandom_range(9) != 0);
               c.last  = (k == plen - 1) && ($urandom_range(7) != 0);
            end
            c.eot = (p == paras - 1) && (k == plen - 1);
            send_char(c, 1'b0, '0);
            sent_items++;
            pos++;
         end
         if ($urandom_range(4) == 0) pos = pos + POS_BITS'($urandom_range(1, 1000));
      end
   endtask

   // ------------------------------------------------------------- checking
   always @(posedge clock) begin : watch_results
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (search_outcomes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer: expected none, actual found %0d position %h",
                     $time, rsp_tuser[0], rsp_tdata);
         end else begin
            want = search_outcomes.pop_front();
            if (rsp_tuser[0] !== want.found) begin
               errors++;
               $display("%0t: found mismatch: expected %0d actual %0d",
                        $time, want.found, rsp_tuser[0]);
            end
            if (rsp_tdata !== want.pos) begin
               errors++;
               $display("%0t: match_position mismatch: expected %h actual %h",
                        $time, want.pos, rsp_tdata);
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("whole_word_substring_finder regression: fail");
      $finish;
   end

   // ------------------------------------------------------------- sequence
   initial begin : run
      logic [POS_BITS-1:0] base;
      int                  target;
      logic                pressed;
      logic                last_was_char;
      pressed       = 1'b0;
      last_was_char = 1'b0;
      clear_scan();
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // after reset the pattern is empty, so nothing can be found
      add_typed(16'h0041, 32'd0, 1'b0, 32'd0);
      // "ab" in either case, whole word, forward from 0
      add_write(CSR_UPPER_LOW, 64'h0000_0000_0042_0041);
      add_write(CSR_UPPER_HIGH, 64'h0);
      add_write(CSR_LOWER_LOW, 64'h0000_0000_0062_0061);
      add_write(CSR_LOWER_HIGH, 64'h0);
      add_write(CSR_PAT_LEN, 64'd2);
      add_write(CSR_WHOLE_WORD, 64'd1);
      add_write(CSR_BACKWARD, 64'd0);
      add_write(CSR_START, 64'd0);
      // spaces around a mixed-case match
      add_char(16'h0020, 32'd10, 1'b1, 1'b0, 1'b0);
      add_char(16'h0061, 32'd11, 1'b0, 1'b0, 1'b0);
      add_char(16'h0042, 32'd12, 1'b0, 1'b0, 1'b0);
      add_char(16'h0020, 32'd13, 1'b0, 1'b1, 1'b1);
      // letter in front spoils the word
      add_char(16'h0078, 32'd20, 1'b1, 1'b0, 1'b0);
      add_char(16'h0061, 32'd21, 1'b0, 1'b0, 1'b0);
      add_char(16'h0062, 32'd22, 1'b0, 1'b1, 1'b1);
      // a new paragraph right after the match closes the word
      add_char(16'h0061, 32'd30, 1'b1, 1'b0, 1'b0);
      add_char(16'h0062, 32'd31, 1'b0, 1'b0, 1'b0);
      add_char(16'h0041, 32'd32, 1'b1, 1'b0, 1'b0);
      add_char(16'h0042, 32'd33, 1'b0, 1'b0, 1'b1);
      // extremes: all-ones / all-zero forms, over-long length, backward from the top
      add_write(CSR_UPPER_LOW, '1);
      add_write(CSR_UPPER_HIGH, '1);
      add_write(CSR_LOWER_LOW, '0);
      add_write(CSR_LOWER_HIGH, '0);
      add_write(CSR_PAT_LEN, 64'd15);
      add_write(CSR_WHOLE_WORD, 64'd0);
      add_write(CSR_BACKWARD, 64'd1);
      add_write(CSR_START, 64'hFFFF_FFFF);
      // eight characters whose positions wrap through zero
      for (int i = 0; i < MAX_PATTERN; i++) begin
         add_char((i % 2) ? 16'h0000 : 16'hFFFF, 32'hFFFF_FFFB + i, i == 0, 1'b0,
                  i == MAX_PATTERN - 1);
      end
      // backward from zero can never find anything
      add_write(CSR_START, 64'd0);
      add_typed(16'hFFFF, 32'd5, 1'b0, 32'd0);

      tx_idle_pct = 36;
      rx_idle_pct = 77;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (last_was_char) drain_results();
            write_reg(directed_rows[i].idx, directed_rows[i].wdata);
            last_was_char = 1'b0;
         end else begin
            send_char(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
            last_was_char = 1'b1;
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // sender slow / receiver slower, then swapped, then flat out
         if (ph < PHASES / 3) begin
            tx_idle_pct = 36;
            rx_idle_pct = 77;
         end else if (ph < 2 * PHASES / 3) begin
            tx_idle_pct = 77;
            rx_idle_pct = 36;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         configure_phase(ph, base);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            run_text(base);
            // sender holds off mid-phase until every owed result has been taken
            if (ph == PRESSURE_PH && !pressed && sent_items >= target - PHASE_ITEMS / 2) begin
               drain_results();
               pressed = 1'b1;
            end
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (search_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("whole_word_substring_finder regression: pass");
      end else begin
         $display("whole_word_substring_finder regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/wfs_pkg.sv
rtl/wfs_cell.sv
rtl/wfs_decide.sv
rtl/whole_word_substring_finder.sv
tb/sv/whole_word_substring_finder_tb.sv
